// ===== rtl/binary_integer_alu_core_assert.svh =====
// Assertion macros for the integer ALU checker
`ifndef BINARY_INTEGER_ALU_CORE_ASSERT_SVH
`define BINARY_INTEGER_ALU_CORE_ASSERT_SVH
`define BIA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BIA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/bia_pkg.sv =====
// Package: word types and operation codes for the integer ALU
`default_nettype none
package bia_pkg;
    localparam logic [2:0] KIND_ADD  = 3'd0;
    localparam logic [2:0] KIND_ABSD = 3'd1;
    localparam logic [2:0] KIND_MUL  = 3'd2;
    localparam logic [2:0] KIND_DIV  = 3'd3;
    localparam logic [2:0] KIND_ONES = 3'd4;
    localparam logic [2:0] KIND_TWOS = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [5:0]  a_digits;
    } in_word_t;

    typedef struct packed {
        logic [63:0] result;
        logic [5:0]  result_digits;
        logic        div_by_zero;
    } out_word_t;
endpackage
`default_nettype wire

// ===== rtl/binary_integer_alu_core.sv =====
// Integer ALU: add, absolute difference, multiply, divide, complements
// An input word passes through the delay-line stage registers, then the output register.
// Throughput: one word per cycle while the output is not stalled; the divider pipeline sets the depth.
// A stall freezes every stage together; an empty output slot lets the pipe advance.
// Reset clears all valid bits; data registers clear as well.
`default_nettype none
module binary_integer_alu_core #(
    parameter int WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire bia_pkg::in_word_t in_word,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output bia_pkg::out_word_t     out_word
);
    localparam int NST = (WIDTH + 3) / 4;

    logic adv;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    logic [WIDTH-1:0] a, b;
    logic [5:0]       d;
    logic [WIDTH:0]   dmask;
    logic [WIDTH:0]   ones;
    logic [WIDTH:0]   twos;
    logic [63:0]      fast;
    logic [5:0]       fdig;

    assign a = in_word.operand_a[WIDTH-1:0];
    assign b = in_word.operand_b[WIDTH-1:0];

    always_comb
    begin
        d = in_word.a_digits;
        if (d == 6'd0)
            d = 6'd1;
        if (d > 6'(WIDTH))
            d = 6'(WIDTH);
        dmask = ({{WIDTH{1'b0}}, 1'b1} << d) - 1'b1;
        ones  = {1'b0, ~a} & dmask;
        twos  = ones + 1'b1;
        fast  = '0;
        fdig  = '0;
        case (in_word.kind)
            bia_pkg::KIND_ADD:  fast = 64'({1'b0, a} + {1'b0, b});
            bia_pkg::KIND_ABSD: fast = (a >= b) ? 64'(a - b) : 64'(b - a);
            bia_pkg::KIND_ONES:
            begin
                fast = 64'(ones);
                fdig = d;
            end
            bia_pkg::KIND_TWOS:
            begin
                fast = 64'(twos);
                fdig = (twos > dmask) ? d + 6'd1 : d;
            end
            default: fast = '0;
        endcase
    end

    // product: multiply into the first stage register, then delay line
    logic [2*WIDTH-1:0] prod_reg [NST];
    logic [63:0]        fast_reg [NST];
    logic [5:0]         fdig_reg [NST];
    logic [2:0]         kind_reg [NST];
    logic               dz_reg   [NST];
    logic               v_reg    [NST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                prod_reg[s] <= '0;
                fast_reg[s] <= '0;
                fdig_reg[s] <= '0;
                kind_reg[s] <= '0;
                dz_reg[s]   <= 1'b0;
                v_reg[s]    <= 1'b0;
            end
        end
        else if (adv)
        begin
            prod_reg[0] <= {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
            fast_reg[0] <= fast;
            fdig_reg[0] <= fdig;
            kind_reg[0] <= in_word.kind;
            dz_reg[0]   <= (in_word.kind == bia_pkg::KIND_DIV) && (b == '0);
            v_reg[0]    <= in_valid;
            for (int s = 1; s < NST; s++)
            begin
                prod_reg[s] <= prod_reg[s-1];
                fast_reg[s] <= fast_reg[s-1];
                fdig_reg[s] <= fdig_reg[s-1];
                kind_reg[s] <= kind_reg[s-1];
                dz_reg[s]   <= dz_reg[s-1];
                v_reg[s]    <= v_reg[s-1];
            end
        end
    end

    logic [WIDTH-1:0] quo;

    bia_div #(.WIDTH(WIDTH), .DIV_BITS(4)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .dividend (a),
        .divisor  (b),
        .quotient (quo)
    );

    bia_pkg::out_word_t out_next;
    logic               out_valid_reg;
    bia_pkg::out_word_t out_word_reg;

    always_comb
    begin
        out_next               = '0;
        out_next.result_digits = fdig_reg[NST-1];
        out_next.div_by_zero   = dz_reg[NST-1];
        case (kind_reg[NST-1])
            bia_pkg::KIND_MUL: out_next.result = 64'(prod_reg[NST-1]);
            bia_pkg::KIND_DIV: out_next.result = dz_reg[NST-1] ? 64'd0 : 64'(quo);
            default:           out_next.result = fast_reg[NST-1];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= v_reg[NST-1];
            out_word_reg  <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
endmodule
`default_nettype wire

// ===== rtl/bia_div.sv =====
// Pipelined restoring divider, DIV_BITS quotient bits per stage
`default_nettype none
module bia_div #(
    parameter int WIDTH    = 32,
    parameter int DIV_BITS = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic      [WIDTH-1:0] quotient
);
    localparam int NST = (WIDTH + DIV_BITS - 1) / DIV_BITS;

    logic [WIDTH-1:0] rem_reg [NST];
    logic [WIDTH-1:0] quo_reg [NST];
    logic [WIDTH-1:0] dvs_reg [NST];
    logic [WIDTH-1:0] rem_next [NST];
    logic [WIDTH-1:0] quo_next [NST];

    always_comb
    begin
        logic [WIDTH:0]   r;
        logic [WIDTH-1:0] q;
        logic [WIDTH-1:0] d;
        int               sp;
        for (int s = 0; s < NST; s++)
        begin
            sp = (s == 0) ? 0 : s - 1;
            r = (s == 0) ? '0 : {1'b0, rem_reg[sp]};
            q = (s == 0) ? dividend : quo_reg[sp];
            d = (s == 0) ? divisor : dvs_reg[sp];
            for (int k = 0; k < DIV_BITS; k++)
            begin
                if (s * DIV_BITS + k < WIDTH)
                begin
                    r = {r[WIDTH-1:0], q[WIDTH-1]};
                    q = {q[WIDTH-2:0], 1'b0};
                    if (r >= {1'b0, d})
                    begin
                        r = r - {1'b0, d};
                        q[0] = 1'b1;
                    end
                end
            end
            rem_next[s] = r[WIDTH-1:0];
            quo_next[s] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                rem_reg[s] <= '0;
                quo_reg[s] <= '0;
                dvs_reg[s] <= '0;
            end
        end
        else if (adv)
        begin
            dvs_reg[0] <= divisor;
            for (int s = 0; s < NST; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
            for (int s = 1; s < NST; s++)
            begin
                dvs_reg[s] <= dvs_reg[s-1];
            end
        end
    end

    assign quotient = quo_reg[NST-1];
endmodule
`default_nettype wire

// ===== rtl/bia_checker.sv =====
// Port checker for the integer ALU, bound to the top level
`default_nettype none
`include "binary_integer_alu_core_assert.svh"
module bia_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire bia_pkg::out_word_t out_word
);
    `BIA_ASSERT_NEXT(hold_out, out_valid && out_stall, out_valid && $stable(out_word))
    `BIA_ASSERT_IMPL(stall_only_full, in_stall, out_valid && out_stall)
    `BIA_ASSERT_IMPL(dz_only_div, out_valid && out_word.div_by_zero, out_word.result == 64'd0)
    `BIA_ASSERT_IMPL(digits_bound, out_valid, out_word.result_digits <= 6'd33)
endmodule

bind binary_integer_alu_core bia_checker u_bia_checker (.*);
`default_nettype wire
